### sv/ber_tlv_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the BER TLV stream parser
// ---------------------------------------------------------------------------
`ifndef BER_TLV_STREAM_PARSER_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define BTSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked while out of reset
`define BTSP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### sv/btsp_pkg.sv
// ---------------------------------------------------------------------------
// btsp_pkg
// Types and constants shared by the BER TLV stream parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btsp_pkg;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 4;
    localparam int OUT_W     = 32;

    // Tags handled specially
    localparam logic [7:0] TAG_INTEGER = 8'h02;
    localparam logic [7:0] TAG_OCTETS  = 8'h04;

    // Role codes as seen on the output
    localparam logic [1:0] ROLE_TAG   = 2'd0;
    localparam logic [1:0] ROLE_LEN1  = 2'd1;
    localparam logic [1:0] ROLE_LONG  = 2'd2;
    localparam logic [1:0] ROLE_VALUE = 2'd3;

    // Parser phase
    typedef enum logic [3:0] {
        PH_TAG   = 4'b0001,
        PH_LEN1  = 4'b0010,
        PH_LONG  = 4'b0100,
        PH_VALUE = 4'b1000
    } phase_t;

    // One result item
    typedef struct packed {
        logic             integer_valid;
        logic [OUT_W-1:0] integer_value;
        logic [OUT_W-1:0] element_length;
        logic             element_done;
        logic             string_byte_valid;
        logic [7:0]       string_byte;
        logic [7:0]       element_tag;
        logic [1:0]       byte_role;
    } result_t;

endpackage

`default_nettype wire

### sv/ber_tlv_stream_parser.sv
// ---------------------------------------------------------------------------
// ber_tlv_stream_parser
// Parses single-byte-tag BER TLV elements from a byte stream.
// ---------------------------------------------------------------------------
// The parser takes one byte per clock while the output register can take
// it, and gives one result transfer per byte. A byte's result is in the
// output register from the cycle after it is accepted, as set by the
// single-stage phase update and length/integer shift. The input stays
// ready while the output register is empty or being drained in the same
// cycle. Raising the start flag (s_tuser) makes the byte a tag byte and
// abandons any element in progress without a done flag.
// m_tlast marks the byte that completes an element.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ber_tlv_stream_parser_assert.svh"

module ber_tlv_stream_parser #(
    parameter int LENGTH_BITS  = 32,
    parameter int INTEGER_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] data_byte
    input  wire logic [btsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] start_of_message
    input  wire logic [btsp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] element_tag, [15:8] string_byte, [47:16] element_length,
    // [79:48] integer_value
    output logic [btsp_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] byte_role, [2] string_byte_valid, [3] integer_valid
    output logic [btsp_pkg::M_TUSER_W-1:0]       m_tuser,
    // element_done
    output logic                                 m_tlast
);
    import btsp_pkg::*;

    logic    s_accept;
    logic    m_valid_reg, m_valid_next;
    result_t step_res;
    result_t res_reg;

    // Accept while the output register is free or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    btsp_parser #(
        .LENGTH_BITS  (LENGTH_BITS),
        .INTEGER_BITS (INTEGER_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (s_accept),
        .data_byte  (s_tdata[7:0]),
        .start_flag (s_tuser[0]),
        .result     (step_res)
    );

    // Hold the result until the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= step_res;
        end
    end

    // Pack the result onto the master side
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.integer_value, res_reg.element_length,
                       res_reg.string_byte, res_reg.element_tag};
    assign m_tuser  = {res_reg.integer_valid, res_reg.string_byte_valid,
                       res_reg.byte_role};
    assign m_tlast  = res_reg.element_done;

    // An integer result only comes with the end of its element
    `BTSP_ASSERT_IMP(a_int_done, aclk, aresetn, m_tvalid && m_tuser[3], m_tlast)
    // A string byte is always a value byte of an OCTET STRING
    `BTSP_ASSERT_IMP(a_str_role, aclk, aresetn, m_tvalid && m_tuser[2],
        (m_tuser[1:0] == ROLE_VALUE) && (m_tdata[7:0] == TAG_OCTETS))
    // Every accepted byte yields a result in the next cycle
    `BTSP_ASSERT_NXT(a_accept_out, aclk, aresetn, s_tvalid && s_tready, m_tvalid)
    // A tag byte never completes an element
    `BTSP_ASSERT_IMP(a_tag_not_done, aclk, aresetn,
        m_tvalid && (m_tuser[1:0] == ROLE_TAG), !m_tlast)

endmodule

`default_nettype wire

### sv/btsp_parser.sv
// ---------------------------------------------------------------------------
// btsp_parser
// TLV phase tracking, length and integer accumulation; one byte per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btsp_parser #(
    parameter int LENGTH_BITS  = 32,
    parameter int INTEGER_BITS = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire logic [7:0]       data_byte,
    input  wire logic             start_flag,
    output btsp_pkg::result_t     result
);
    import btsp_pkg::*;

    phase_t                  phase_reg, phase_next, phase_cur;
    logic [7:0]              tag_reg, tag_next;
    logic [6:0]              len_left_reg, len_left_next;
    logic [LENGTH_BITS-1:0]  len_acc_reg, len_acc_next;
    logic [LENGTH_BITS-1:0]  val_left_reg, val_left_next;
    logic [INTEGER_BITS-1:0] int_acc_reg, int_acc_next;
    logic                    len_out, done, len_known, str_valid;
    logic [1:0]              role;

    // Next state and result for the byte on the input
    always_comb begin
        phase_cur     = start_flag ? PH_TAG : phase_reg;
        phase_next    = phase_cur;
        tag_next      = tag_reg;
        len_left_next = len_left_reg;
        len_acc_next  = len_acc_reg;
        val_left_next = val_left_reg;
        int_acc_next  = int_acc_reg;
        len_out       = 1'b0;
        done          = 1'b0;
        len_known     = 1'b0;
        str_valid     = 1'b0;
        role          = ROLE_TAG;
        case (phase_cur)
            PH_TAG: begin
                role          = ROLE_TAG;
                tag_next      = data_byte;
                len_acc_next  = '0;
                len_left_next = '0;
                val_left_next = '0;
                int_acc_next  = '0;
                phase_next    = PH_LEN1;
            end
            PH_LEN1: begin
                role = ROLE_LEN1;
                if (!data_byte[7]) begin
                    len_acc_next = LENGTH_BITS'(data_byte);
                    len_known    = 1'b1;
                end else begin
                    len_acc_next  = '0;
                    len_left_next = data_byte[6:0];
                    if (data_byte[6:0] == 7'd0) begin
                        len_known = 1'b1;
                    end else begin
                        phase_next = PH_LONG;
                    end
                end
            end
            PH_LONG: begin
                role          = ROLE_LONG;
                len_acc_next  = (len_acc_reg << 8) | LENGTH_BITS'(data_byte);
                len_left_next = len_left_reg - 7'd1;
                if (len_left_next == 7'd0) begin
                    len_known = 1'b1;
                end
            end
            PH_VALUE: begin
                role    = ROLE_VALUE;
                len_out = 1'b1;
                if (tag_reg == TAG_OCTETS) begin
                    str_valid = 1'b1;
                end else if (tag_reg == TAG_INTEGER) begin
                    int_acc_next = (int_acc_reg << 8) | INTEGER_BITS'(data_byte);
                end
                val_left_next = val_left_reg - LENGTH_BITS'(1);
                if (val_left_next == '0) begin
                    done       = 1'b1;
                    phase_next = PH_TAG;
                end
            end
            default: begin
                phase_next = PH_TAG;
            end
        endcase

        // Length complete: end an empty element or move to the value bytes
        if (len_known) begin
            len_out = 1'b1;
            if (len_acc_next == '0) begin
                done       = 1'b1;
                phase_next = PH_TAG;
            end else begin
                val_left_next = len_acc_next;
                phase_next    = PH_VALUE;
            end
        end
    end

    // Drive the result item
    always_comb begin
        result.byte_role         = role;
        result.element_tag       = tag_next;
        result.string_byte       = str_valid ? data_byte : 8'd0;
        result.string_byte_valid = str_valid;
        result.element_done      = done;
        result.element_length    = len_out ? OUT_W'(len_acc_next) : '0;
        result.integer_value     = OUT_W'(int_acc_next);
        result.integer_valid     = done && (tag_next == TAG_INTEGER);
    end

    // Advance the parser state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_TAG;
            tag_reg      <= '0;
            len_left_reg <= '0;
            len_acc_reg  <= '0;
            val_left_reg <= '0;
            int_acc_reg  <= '0;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            tag_reg      <= tag_next;
            len_left_reg <= len_left_next;
            len_acc_reg  <= len_acc_next;
            val_left_reg <= val_left_next;
            int_acc_reg  <= int_acc_next;
        end
    end

endmodule

`default_nettype wire
